### src/keyframe_vector_interpolator_defines.svh
// assertion macros for the keyframe vector interpolator
// no dependencies; included by files that check their own logic
`ifndef KEYFRAME_VECTOR_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_VECTOR_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define KVI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define KVI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KVI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define KVI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/kvi_pkg.sv
// shared types and constants of the keyframe vector interpolator
// no dependencies
package kvi_pkg;

    localparam int unsigned KVI_MAX_KEYS = 64;
    localparam int unsigned TIME_W = 24;
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned KC_W   = 7;
    localparam int unsigned FAC_W  = 16;
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // register select bit of paddr
    localparam logic REG_KEY_COUNT = 1'b0;
    localparam logic [KC_W-1:0] KEY_COUNT_RST = 7'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SGL_W,
        S_SGL_FIN,
        S_SCAN,
        S_PAST_W,
        S_PAST_FIN,
        S_SEG_W,
        S_DIV_INIT,
        S_DIV,
        S_MUL,
        S_ACC,
        S_OUT
    } t_kvi_state;

    typedef struct packed {
        logic       mem_we;
        logic       ld_q;
        logic       rd_en;
        logic       cap_a;
        logic       cap_b;
        logic       div_init;
        logic       div_step;
        logic       mul_go;
        logic       acc_go;
        logic       fin_copy;
        logic       fin_past;
        logic       out_load;
        logic [1:0] comp;
    } t_kvi_cmd;

    typedef struct packed {
        logic q_lt_rd;
        logic q_ge_a;
    } t_kvi_sts;

endpackage

### src/kvi_in_if.sv
// input channel of the keyframe vector interpolator
// depends on kvi_pkg
interface kvi_in_if;
    import kvi_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [IDX_W-1:0]  key_index;
    logic [TIME_W-1:0] key_time;
    logic signed [VAL_W-1:0] key_x;
    logic signed [VAL_W-1:0] key_y;
    logic signed [VAL_W-1:0] key_z;
    logic [TIME_W-1:0] query_time;

    modport source(output valid, func, key_index, key_time, key_x, key_y, key_z,
                   query_time, input ready);
    modport sink(input valid, func, key_index, key_time, key_x, key_y, key_z,
                 query_time, output ready);
endinterface

### src/kvi_out_if.sv
// result channel of the keyframe vector interpolator
// depends on kvi_pkg
interface kvi_out_if;
    import kvi_pkg::*;

    logic valid;
    logic ready;
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;
    logic signed [VAL_W-1:0] out_z;
    logic [IDX_W-1:0] segment;
    logic             past_end;

    modport source(output valid, out_x, out_y, out_z, segment, past_end, input ready);
    modport sink(input valid, out_x, out_y, out_z, segment, past_end, output ready);
endinterface

### src/kvi_ctrl.sv
// controller: sequences key scan, division and per-component blend
// depends on kvi_pkg
module kvi_ctrl #(
    parameter int unsigned MAX_KEYS = kvi_pkg::KVI_MAX_KEYS,
    parameter int unsigned AW = $clog2(MAX_KEYS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_func,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    input  logic [kvi_pkg::KC_W-1:0] i_key_count,
    input  kvi_pkg::t_kvi_sts        i_sts,
    output kvi_pkg::t_kvi_cmd        o_cmd,
    output logic [AW-1:0]            o_rd_addr,
    output logic [kvi_pkg::IDX_W-1:0] o_seg
);
    import kvi_pkg::*;

    localparam int unsigned CW = $clog2(MAX_KEYS + 1);
    localparam int unsigned NW = (CW > KC_W) ? CW : KC_W;
    localparam int unsigned EW = CW + IDX_W;

    t_kvi_state r_state, n_state;
    logic [CW-1:0] r_i, n_i;
    logic [3:0]    r_cnt, n_cnt;
    logic [1:0]    r_comp, n_comp;
    logic          r_out_vld, n_out_vld;

    logic [NW-1:0] kc_w;
    logic [NW-1:0] n_w;
    logic [CW-1:0] n_keys, i1, i2, n_last;
    logic [EW-1:0] seg_i_ext, seg_last_ext;
    logic          accept;

    // clamp key count to 1..MAX_KEYS
    always_comb begin
        kc_w = NW'(i_key_count);
        if (kc_w == '0) begin
            n_w = NW'(1);
        end else if (kc_w > NW'(MAX_KEYS)) begin
            n_w = NW'(MAX_KEYS);
        end else begin
            n_w = kc_w;
        end
    end

    assign n_keys = n_w[CW-1:0];
    assign i1 = r_i + CW'(1);
    assign i2 = r_i + CW'(2);
    assign n_last = n_keys - CW'(1);
    assign seg_i_ext = EW'(r_i);
    assign seg_last_ext = EW'(n_last);
    assign accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_cnt = r_cnt;
        n_comp = r_comp;
        case (r_state)
            S_IDLE: begin
                if (accept && i_in_func == FUNC_QUERY) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_i = '0;
                n_state = (n_keys == CW'(1)) ? S_SGL_W : S_SCAN;
            end
            S_SGL_W:   n_state = S_SGL_FIN;
            S_SGL_FIN: n_state = S_OUT;
            S_SCAN: begin
                if (i_sts.q_lt_rd) begin
                    n_state = S_SEG_W;
                end else if (i2 >= n_keys) begin
                    n_state = S_PAST_W;
                end else begin
                    n_i = i1;
                end
            end
            S_PAST_W:   n_state = S_PAST_FIN;
            S_PAST_FIN: n_state = S_OUT;
            S_SEG_W:    n_state = S_DIV_INIT;
            S_DIV_INIT: begin
                n_cnt = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_comp = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_ACC;
            S_ACC: begin
                if (r_comp == 2'd2) begin
                    n_state = S_OUT;
                end else begin
                    n_comp = r_comp + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_OUT: begin
                if (!r_out_vld || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.comp = r_comp;
        o_rd_addr = '0;
        o_seg = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.ld_q = accept && (i_in_func == FUNC_QUERY);
                o_cmd.mem_we = accept && (i_in_func == FUNC_WRITE);
            end
            S_START: begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr = (n_keys == CW'(1)) ? '0 : AW'(1);
            end
            S_SGL_W: o_cmd.cap_a = 1'b1;
            S_SGL_FIN: begin
                o_cmd.fin_copy = 1'b1;
                o_cmd.fin_past = i_sts.q_ge_a;
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.q_lt_rd) begin
                    o_cmd.cap_b = 1'b1;
                    o_rd_addr = r_i[AW-1:0];
                end else if (i2 >= n_keys) begin
                    o_rd_addr = n_last[AW-1:0];
                end else begin
                    o_rd_addr = i2[AW-1:0];
                end
            end
            S_PAST_W: o_cmd.cap_a = 1'b1;
            S_PAST_FIN: begin
                o_cmd.fin_copy = 1'b1;
                o_cmd.fin_past = 1'b1;
                o_seg = seg_last_ext[IDX_W-1:0];
            end
            S_SEG_W:    o_cmd.cap_a = 1'b1;
            S_DIV_INIT: o_cmd.div_init = 1'b1;
            S_DIV:      o_cmd.div_step = 1'b1;
            S_MUL:      o_cmd.mul_go = 1'b1;
            S_ACC: begin
                o_cmd.acc_go = 1'b1;
                o_seg = seg_i_ext[IDX_W-1:0];
            end
            S_OUT: o_cmd.out_load = !r_out_vld || i_out_ready;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i <= '0;
            r_cnt <= '0;
            r_comp <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i <= n_i;
            r_cnt <= n_cnt;
            r_comp <= n_comp;
            r_out_vld <= n_out_vld;
        end
    end
endmodule

### src/kvi_dpath.sv
// datapath: key table memory, serial divider, shared multiplier, result registers
// depends on kvi_pkg
module kvi_dpath #(
    parameter int unsigned MAX_KEYS = kvi_pkg::KVI_MAX_KEYS,
    parameter int unsigned AW = $clog2(MAX_KEYS)
) (
    input  logic                       i_clk,
    input  kvi_pkg::t_kvi_cmd          i_cmd,
    input  logic [AW-1:0]              i_rd_addr,
    input  logic [kvi_pkg::IDX_W-1:0]  i_seg,
    output kvi_pkg::t_kvi_sts          o_sts,
    input  logic [kvi_pkg::IDX_W-1:0]  i_key_index,
    input  logic [kvi_pkg::TIME_W-1:0] i_key_time,
    input  logic [kvi_pkg::VAL_W-1:0]  i_key_x,
    input  logic [kvi_pkg::VAL_W-1:0]  i_key_y,
    input  logic [kvi_pkg::VAL_W-1:0]  i_key_z,
    input  logic [kvi_pkg::TIME_W-1:0] i_query_time,
    output logic [kvi_pkg::VAL_W-1:0]  o_out_x,
    output logic [kvi_pkg::VAL_W-1:0]  o_out_y,
    output logic [kvi_pkg::VAL_W-1:0]  o_out_z,
    output logic [kvi_pkg::IDX_W-1:0]  o_segment,
    output logic                       o_past_end
);
    import kvi_pkg::*;

    localparam int unsigned XW = AW + IDX_W + 1;
    localparam int unsigned DW = VAL_W + 1;
    localparam int unsigned PW = DW + FAC_W + 1;
    localparam int unsigned SW = PW - FAC_W + 1;

    logic [TIME_W-1:0]   mem_t [MAX_KEYS];
    logic [3*VAL_W-1:0]  mem_v [MAX_KEYS];

    logic [TIME_W-1:0]         r_rd_t, r_ta, r_tb, r_q, r_dt;
    logic [2:0][VAL_W-1:0]     r_rd_v, r_va, r_vb, r_res;
    logic [TIME_W:0]           r_rem;
    logic [FAC_W-1:0]          r_fac;
    logic                      r_fz;
    logic signed [PW-1:0]      r_prod;
    logic [IDX_W-1:0]          r_seg;
    logic                      r_past;

    logic [XW-1:0]             wr_ext;
    logic                      wr_ok;
    logic [TIME_W:0]           rem_sh;
    logic                      q_bit;
    logic signed [DW-1:0]      delta;
    logic signed [FAC_W:0]     fac_s;
    logic signed [SW-1:0]      sum;
    logic [VAL_W-1:0]          sat;

    assign wr_ext = XW'(i_key_index);
    assign wr_ok = wr_ext < XW'(MAX_KEYS);

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we && wr_ok) begin
            mem_t[wr_ext[AW-1:0]] <= i_key_time;
            mem_v[wr_ext[AW-1:0]] <= {i_key_z, i_key_y, i_key_x};
        end
        if (i_cmd.rd_en) begin
            r_rd_t <= mem_t[i_rd_addr];
            r_rd_v <= mem_v[i_rd_addr];
        end
    end

    assign o_sts.q_lt_rd = r_q < r_rd_t;
    assign o_sts.q_ge_a = r_q >= r_ta;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem[TIME_W-1:0], 1'b0};
    assign q_bit = rem_sh >= {1'b0, r_dt};

    assign delta = $signed({r_vb[i_cmd.comp][VAL_W-1], r_vb[i_cmd.comp]})
                 - $signed({r_va[i_cmd.comp][VAL_W-1], r_va[i_cmd.comp]});
    assign fac_s = r_fz ? '0 : $signed({1'b0, r_fac});

    // floor shift of product, then saturate to 32 bits
    assign sum = $signed({{(SW-VAL_W){r_va[i_cmd.comp][VAL_W-1]}}, r_va[i_cmd.comp]})
               + $signed({r_prod[PW-1], r_prod[PW-1:FAC_W]});
    always_comb begin
        if (sum > $signed(SW'({1'b0, {(VAL_W-1){1'b1}}}))) begin
            sat = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (sum < $signed({{(SW-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}})) begin
            sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            sat = sum[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_q) begin
            r_q <= i_query_time;
        end
        if (i_cmd.cap_a) begin
            r_ta <= r_rd_t;
            r_va <= r_rd_v;
        end
        if (i_cmd.cap_b) begin
            r_tb <= r_rd_t;
            r_vb <= r_rd_v;
        end
        if (i_cmd.div_init) begin
            r_rem <= {1'b0, r_q - r_ta};
            r_dt <= r_tb - r_ta;
            r_fac <= '0;
            r_fz <= !((r_tb > r_ta) && (r_q > r_ta));
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? (rem_sh - {1'b0, r_dt}) : rem_sh;
            r_fac <= {r_fac[FAC_W-2:0], q_bit};
        end
        if (i_cmd.mul_go) begin
            r_prod <= delta * fac_s;
        end
        if (i_cmd.acc_go) begin
            r_res[i_cmd.comp] <= sat;
            r_seg <= i_seg;
            r_past <= 1'b0;
        end
        if (i_cmd.fin_copy) begin
            r_res <= r_va;
            r_seg <= i_seg;
            r_past <= i_cmd.fin_past;
        end
        if (i_cmd.out_load) begin
            o_out_x <= r_res[0];
            o_out_y <= r_res[1];
            o_out_z <= r_res[2];
            o_segment <= r_seg;
            o_past_end <= r_past;
        end
    end
endmodule

### src/keyframe_vector_interpolator.sv
// keyframe vector interpolator: a query scans the keys one per cycle, then runs a serial
// divider for a 16-bit factor and makes three passes through the shared multiplier; a key
// write leaves the block ready for the next word. the next word is taken in the cycle
// after the result register loads, so a new word can be taken while a result still waits
// synchronous active-low reset clears control and sets key_count to 1; table contents
// stay undefined until written
`include "keyframe_vector_interpolator_defines.svh"

// top level: apb register, controller and datapath
// depends on kvi_pkg, kvi_in_if, kvi_out_if, kvi_ctrl, kvi_dpath
module keyframe_vector_interpolator #(
    parameter int unsigned MAX_KEYS = kvi_pkg::KVI_MAX_KEYS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    kvi_in_if.sink                     i_in,
    kvi_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kvi_pkg::APB_AW-1:0] paddr,
    input  logic [kvi_pkg::APB_DW-1:0] pwdata,
    output logic [kvi_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import kvi_pkg::*;

    localparam int unsigned AW = $clog2(MAX_KEYS);

    logic [KC_W-1:0] r_key_count;
    t_kvi_cmd        cmd;
    t_kvi_sts        sts;
    logic [AW-1:0]   rd_addr;
    logic [IDX_W-1:0] seg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_KEY_COUNT) ? APB_DW'(r_key_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= KEY_COUNT_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_KEY_COUNT) begin
            r_key_count <= pwdata[KC_W-1:0];
        end
    end

    kvi_ctrl #(.MAX_KEYS(MAX_KEYS), .AW(AW)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_func   (i_in.func),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_key_count (r_key_count),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr),
        .o_seg       (seg)
    );

    kvi_dpath #(.MAX_KEYS(MAX_KEYS), .AW(AW)) u_dpath (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_rd_addr    (rd_addr),
        .i_seg        (seg),
        .o_sts        (sts),
        .i_key_index  (i_in.key_index),
        .i_key_time   (i_in.key_time),
        .i_key_x      (i_in.key_x),
        .i_key_y      (i_in.key_y),
        .i_key_z      (i_in.key_z),
        .i_query_time (i_in.query_time),
        .o_out_x      (o_out.out_x),
        .o_out_y      (o_out.out_y),
        .o_out_z      (o_out.out_z),
        .o_segment    (o_out.segment),
        .o_past_end   (o_out.past_end)
    );

    `KVI_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, i_in.valid && i_in.ready && i_in.func == FUNC_QUERY, !i_in.ready, "query word accepted but block still ready")
    `KVI_ASSERT_NEXT(a_write_one_cycle, i_clk, i_rst_n, i_in.valid && i_in.ready && i_in.func == FUNC_WRITE, i_in.ready, "key write did not finish in one cycle")
    `KVI_ASSERT_IMPL(a_we_on_accept, i_clk, i_rst_n, cmd.mem_we, i_in.valid && i_in.ready && i_in.func == FUNC_WRITE, "table written without an accepted write word")
endmodule
